@@ rtl/hlc_pkg.sv @@
package hlc_pkg;

	// Channel count clamp: hop sequence length and index width
	localparam int MAX_CHANNELS = 64;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int CHAN_LIMIT_I = (MAX_CHANNELS < (1 << IDX_W)) ? MAX_CHANNELS : (1 << IDX_W);
	localparam logic [CNT_W-1:0] CHAN_LIMIT = CNT_W'(CHAN_LIMIT_I);

	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_PHASE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 2'd3;

	localparam logic OP_FRAME  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	localparam logic [3:0] PARTIAL_LIMIT = 4'd10;
	localparam logic [3:0] PARTIAL_MAX   = 4'd15;
	localparam logic [7:0] MISS_MAX      = 8'd255;

	typedef struct packed {
		logic [CNT_W-1:0] chan_count;     // effective channel count, 1..CHAN_LIMIT
		logic             chan_reload;    // channels_in_use written this cycle
		logic [3:0]       frames_per_hop;
		logic [2:0]       lock_hop_phase;
		logic [7:0]       fail_limit;
	} cfg_t;

endpackage

@@ rtl/hlc_if.sv @@
interface hlc_item_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic       received_ok;
	logic [2:0] sender_hop_count;

	modport source (output valid, operation, received_ok, sender_hop_count, input ready);
	modport sink   (input valid, operation, received_ok, sender_hop_count, output ready);
endinterface

interface hlc_result_if;
	logic       valid;
	logic       ready;
	logic [5:0] channel_index;
	logic       retune;
	logic [1:0] link_state;

	modport source (output valid, channel_index, retune, link_state, input ready);
	modport sink   (input valid, channel_index, retune, link_state, output ready);
endinterface

@@ rtl/hlc_cfg.sv @@
module hlc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [hlc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [hlc_pkg::CFG_DATA_W-1:0] wr_data,
	output hlc_pkg::cfg_t                  cfg
);
	import hlc_pkg::*;

	logic [CNT_W-1:0] channels_q;
	logic [3:0]       frames_q;
	logic [2:0]       lock_phase_q;
	logic [7:0]       fail_limit_q;
	logic [CNT_W-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q   <= 7'd8;
			frames_q     <= 4'd4;
			lock_phase_q <= 3'd0;
			fail_limit_q <= 8'd10;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHANNELS:   channels_q   <= wr_data[CNT_W-1:0];
				REG_FRAMES:     frames_q     <= wr_data[3:0];
				REG_LOCK_PHASE: lock_phase_q <= wr_data[2:0];
				REG_FAIL_LIMIT: fail_limit_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// Zero counts as one channel; saturate at the sequence limit
	always_comb begin
		if (channels_q == '0)
			count = CNT_W'(1);
		else if (channels_q > CHAN_LIMIT)
			count = CHAN_LIMIT;
		else
			count = channels_q;
	end

	assign cfg.chan_count     = count;
	assign cfg.chan_reload    = wr_en && (wr_index == REG_CHANNELS);
	assign cfg.frames_per_hop = frames_q;
	assign cfg.lock_hop_phase = lock_phase_q;
	assign cfg.fail_limit     = fail_limit_q;

endmodule

@@ rtl/hlc_core.sv @@
module hlc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  hlc_pkg::cfg_t cfg,
	hlc_item_if.sink      item,
	hlc_result_if.source  result
);
	import hlc_pkg::*;

	typedef enum logic [1:0] {
		LINK_SCAN    = 2'd0,
		LINK_PARTIAL = 2'd1,
		LINK_FULL    = 2'd2
	} link_t;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic       ok_s1;
	logic [2:0] shc_s1;

	// result register
	logic             valid_s2;
	logic [IDX_W-1:0] chan_s2;
	logic             retune_s2;
	logic [1:0]       link_s2;

	// link state
	link_t            link_q;
	logic [IDX_W-1:0] chan_q;
	logic [IDX_W-1:0] red_q;     // chan_q reduced modulo the channel count
	logic [3:0]       hop_q;
	logic [IDX_W-1:0] sweep_q;
	logic [2:0]       scan_q;
	logic [3:0]       partial_q;
	logic [7:0]       miss_q;

	logic busy;
	logic s2_free;
	logic advance;

	// next-state logic
	link_t            link_d;
	logic [3:0]       hop_d;
	logic [3:0]       partial_d;
	logic [7:0]       miss_d;
	logic             do_step;
	logic             step_up;
	logic [1:0]       step_amt;
	logic [4:0]       hop_inc;
	logic [7:0]       up0;
	logic [7:0]       up1;
	logic [7:0]       up2;
	logic [CNT_W-1:0] down_v;
	logic [IDX_W-1:0] idx_new;
	logic [CNT_W-1:0] sweep_inc;
	logic [3:0]       scan_inc;
	logic [IDX_W-1:0] sweep_new;
	logic [2:0]       scan_new;

	assign busy    = {1'b0, red_q} >= cfg.chan_count;
	assign s2_free = !valid_s2 || result.ready;
	assign advance = valid_s1 && !busy && s2_free;

	assign item.ready = !valid_s1 || advance;

	always_comb begin
		link_d    = link_q;
		hop_d     = hop_q;
		partial_d = partial_q;
		miss_d    = miss_q;
		do_step   = 1'b0;
		step_up   = 1'b0;
		step_amt  = 2'd0;
		hop_inc   = {1'b0, hop_q} + 5'd1;

		if (op_s1 == OP_FRAME) begin
			if (hop_inc >= {1'b0, cfg.frames_per_hop})
				hop_d = 4'd0;
			else
				hop_d = hop_inc[3:0];
			if (link_q == LINK_SCAN) begin
				do_step = (hop_d == {1'b0, scan_q});
			end else if (link_q == LINK_FULL) begin
				do_step  = (hop_d == {1'b0, cfg.lock_hop_phase});
				step_up  = 1'b1;
				step_amt = 2'd1;
			end
		end else begin
			if (ok_s1) begin
				miss_d = 8'd0;
				hop_d  = {1'b0, shc_s1};
				if (link_q == LINK_SCAN) begin
					do_step   = 1'b1;
					step_up   = 1'b1;
					step_amt  = 2'd2;
					link_d    = LINK_PARTIAL;
					partial_d = 4'd0;
				end else if (link_q == LINK_PARTIAL) begin
					if (partial_q < PARTIAL_MAX)
						partial_d = partial_q + 4'd1;
					link_d = (partial_d > PARTIAL_LIMIT) ? LINK_SCAN : LINK_FULL;
				end
			end else if (miss_q < MISS_MAX) begin
				miss_d = miss_q + 8'd1;
			end
			if (miss_d >= cfg.fail_limit) begin
				miss_d = 8'd0;
				link_d = LINK_SCAN;
			end
		end
	end

	// Channel step from the reduced index: at most two subtractions wrap it back
	always_comb begin
		up0    = {2'b00, red_q} + {6'd0, step_amt};
		up1    = (up0 >= {1'b0, cfg.chan_count}) ? up0 - {1'b0, cfg.chan_count} : up0;
		up2    = (up1 >= {1'b0, cfg.chan_count}) ? up1 - {1'b0, cfg.chan_count} : up1;
		down_v = (red_q == '0) ? cfg.chan_count - CNT_W'(1) : {1'b0, red_q} - CNT_W'(1);
		idx_new = step_up ? up2[IDX_W-1:0] : down_v[IDX_W-1:0];

		sweep_inc = {1'b0, sweep_q} + CNT_W'(1);
		scan_inc  = {1'b0, scan_q} + 4'd1;
		if (sweep_inc >= cfg.chan_count) begin
			sweep_new = '0;
			if (scan_inc >= cfg.frames_per_hop || scan_inc[3])
				scan_new = 3'd0;
			else
				scan_new = scan_inc[2:0];
		end else begin
			sweep_new = sweep_inc[IDX_W-1:0];
			scan_new  = scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1  <= item.operation;
			ok_s1  <= item.received_ok;
			shc_s1 <= item.sender_hop_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chan_s2   <= do_step ? idx_new : chan_q;
			retune_s2 <= do_step;
			link_s2   <= link_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q    <= LINK_SCAN;
			chan_q    <= '0;
			red_q     <= '0;
			hop_q     <= '0;
			sweep_q   <= '0;
			scan_q    <= '0;
			partial_q <= '0;
			miss_q    <= '0;
		end else begin
			// restart the reduction from the raw index whenever channels_in_use is written
			if (cfg.chan_reload)
				red_q <= chan_q;
			else if (busy)
				red_q <= red_q - cfg.chan_count[IDX_W-1:0];
			else if (advance && do_step)
				red_q <= idx_new;

			if (advance) begin
				link_q    <= link_d;
				hop_q     <= hop_d;
				partial_q <= partial_d;
				miss_q    <= miss_d;
				if (do_step) begin
					chan_q  <= idx_new;
					sweep_q <= sweep_new;
					scan_q  <= scan_new;
				end
			end
		end
	end

	assign result.valid         = valid_s2;
	assign result.channel_index = chan_s2;
	assign result.retune        = retune_s2;
	assign result.link_state    = link_s2;

	a_step_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		advance && do_step |=> chan_q == red_q)
		else $error("stepped index and reduced index disagree");

	a_no_work_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> {1'b0, red_q} < cfg.chan_count)
		else $error("item processed with an unreduced channel index");

	a_hop_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_FRAME && !cfg.chan_reload
		|=> hop_q < cfg.frames_per_hop || hop_q == 4'd0)
		else $error("hop counter beyond frames per hop after a frame tick");

	a_miss_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_REPORT |=> miss_q < cfg.fail_limit || miss_q == 8'd0)
		else $error("miss counter left at or above the fail limit");

endmodule

@@ rtl/hop_lock_controller_top.sv @@
// Lock and channel-hop controller: each beat on item is either a frame-start tick
// (operation 0) or a receive report (operation 1) and yields exactly one beat on result
// with the channel index, a retune flag and the link state after the update. Items are
// taken one per clock cycle unless a reduction is pending or the result is stalled; each
// passes through the input register, then the result register holding the updated state,
// and a stalled result keeps its successor in the input register. Configuration must be
// written through wr_en/wr_index/wr_data only while the block is idle; the block itself
// does not enforce this. After a write to channels_in_use the current index is reduced
// modulo the new count by one subtraction per cycle, and item processing waits until done.
module hop_lock_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	hlc_item_if.sink                       item,
	hlc_result_if.source                   result,
	input  logic                           wr_en,
	input  logic [hlc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [hlc_pkg::CFG_DATA_W-1:0] wr_data
);
	import hlc_pkg::*;

	cfg_t cfg;

	hlc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	hlc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

endmodule
